### src/pidd_pkg.sv
// Shared constants and types for the deadband PID controller.
// Depends on nothing; every RTL file refers to it by scoped names.
`default_nettype none

package pidd_pkg;

    // Binary point of the Q-format gains; products are shifted right by this.
    localparam int FRAC_BITS = 8;

    // Field and register widths.
    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 16;
    localparam int OLIM_W   = 15;
    localparam int ILIM_W   = 23;
    localparam int DZ_W     = 16;
    localparam int CFG_W    = 23;
    localparam int IDX_W    = 3;

    // Internal arithmetic widths.
    localparam int ERR_W  = SAMPLE_W + 1;        // set minus actual
    localparam int DERR_W = ERR_W + 1;           // error difference
    localparam int INT_W  = 24;                  // integral accumulator
    localparam int P_W    = GAIN_W + ERR_W;      // gain_p * error
    localparam int I_W    = GAIN_W + INT_W;      // gain_i * integral
    localparam int D_W    = GAIN_W + DERR_W;     // gain_d * error difference
    localparam int SUM_W  = I_W - FRAC_BITS + 3; // sum of three shifted terms

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        CFG_GAIN_P     = 3'd0,
        CFG_GAIN_I     = 3'd1,
        CFG_GAIN_D     = 3'd2,
        CFG_OUT_LIMIT  = 3'd3,
        CFG_INT_LIMIT  = 3'd4,
        CFG_DEAD_ZONE  = 3'd5
    } t_cfg_idx;

endpackage : pidd_pkg

`default_nettype wire

### src/pid_controller_deadband_core.sv
// Positional PID controller with deadband, built as a four-register stream pipeline.
// Depends on pidd_pkg for widths, the fraction size and register indexes.
// A result word passes the input register, the deadband and integral stage, the gain products
// and the sum and output clamp. Throughput: one word per cycle while m_axis_tready is high;
// the state recurrence closes in one add-and-clamp stage.
// Reset (synchronous, active low) clears gains, limits, integral, previous error, valid flags.
`default_nettype none

module pid_controller_deadband_core (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // Configuration write port.
    input  wire logic                         i_cfg_we,
    input  wire logic [pidd_pkg::IDX_W-1:0]   i_cfg_idx,
    input  wire logic [pidd_pkg::CFG_W-1:0]   i_cfg_data,
    // Input stream.
    input  wire logic                         s_axis_tvalid,
    output      logic                         s_axis_tready,
    input  wire logic [31:0]                  s_axis_tdata,  // set_value[15:0], actual_value[31:16]
    // Result stream.
    output      logic                         m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output      logic [15:0]                  m_axis_tdata,  // drive[15:0]
    output      logic [0:0]                   m_axis_tuser   // in_deadband[0]
);

    localparam int ERR_W  = pidd_pkg::ERR_W;
    localparam int DERR_W = pidd_pkg::DERR_W;
    localparam int INT_W  = pidd_pkg::INT_W;
    localparam int FB     = pidd_pkg::FRAC_BITS;
    localparam int P_W    = pidd_pkg::P_W;
    localparam int I_W    = pidd_pkg::I_W;
    localparam int D_W    = pidd_pkg::D_W;
    localparam int PS_W   = P_W - FB;
    localparam int IS_W   = I_W - FB;
    localparam int DS_W   = D_W - FB;
    localparam int SUM_W  = pidd_pkg::SUM_W;
    localparam int ACC_W  = INT_W + 1;

    // ------------------------------------------------------------------
    // Configuration registers, read directly by the datapath. Writes must
    // come only while the pipeline is empty; this is not enforced.
    // ------------------------------------------------------------------
    logic signed [pidd_pkg::GAIN_W-1:0] r_gain_p, r_gain_i, r_gain_d;
    logic        [pidd_pkg::OLIM_W-1:0] r_out_limit;
    logic        [pidd_pkg::ILIM_W-1:0] r_int_limit;
    logic        [pidd_pkg::DZ_W-1:0]   r_dead_zone;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p    <= '0;
            r_gain_i    <= '0;
            r_gain_d    <= '0;
            r_out_limit <= '0;
            r_int_limit <= '0;
            r_dead_zone <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pidd_pkg::CFG_GAIN_P:    r_gain_p    <= i_cfg_data[pidd_pkg::GAIN_W-1:0];
                pidd_pkg::CFG_GAIN_I:    r_gain_i    <= i_cfg_data[pidd_pkg::GAIN_W-1:0];
                pidd_pkg::CFG_GAIN_D:    r_gain_d    <= i_cfg_data[pidd_pkg::GAIN_W-1:0];
                pidd_pkg::CFG_OUT_LIMIT: r_out_limit <= i_cfg_data[pidd_pkg::OLIM_W-1:0];
                pidd_pkg::CFG_INT_LIMIT: r_int_limit <= i_cfg_data[pidd_pkg::ILIM_W-1:0];
                pidd_pkg::CFG_DEAD_ZONE: r_dead_zone <= i_cfg_data[pidd_pkg::DZ_W-1:0];
                default: begin
                    // Indexes past the register list are ignored.
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control. Each stage loads when it is empty or when its
    // contents move on in the same cycle. The output register doubles as
    // the skid stage toward the consumer.
    // ------------------------------------------------------------------
    logic r_a_vld, r_b_vld, r_c_vld, r_o_vld;
    logic adv_o, adv_c, adv_b, adv_a;

    assign adv_o = !r_o_vld || m_axis_tready;
    assign adv_c = !r_c_vld || adv_o;
    assign adv_b = !r_b_vld || adv_c;
    assign adv_a = !r_a_vld || adv_b;
    assign s_axis_tready = adv_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (adv_a) r_a_vld <= s_axis_tvalid;
            if (adv_b) r_b_vld <= r_a_vld;
            if (adv_c) r_c_vld <= r_b_vld;
            if (adv_o) r_o_vld <= r_c_vld;
        end
    end

    // ------------------------------------------------------------------
    // Stage A: input register holding the error, set minus actual.
    // ------------------------------------------------------------------
    logic signed [pidd_pkg::SAMPLE_W-1:0] set_value, actual_value;
    logic signed [ERR_W-1:0]              n_a_err;
    logic signed [ERR_W-1:0]              r_a_err;

    assign set_value    = s_axis_tdata[15:0];
    assign actual_value = s_axis_tdata[31:16];
    assign n_a_err = $signed({set_value[15], set_value})
                   - $signed({actual_value[15], actual_value});

    always_ff @(posedge i_clk) begin
        if (adv_a && s_axis_tvalid) begin
            r_a_err <= n_a_err;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: deadband test and the controller state update. The state
    // changes exactly once per word, when the word leaves stage A.
    // ------------------------------------------------------------------
    logic signed [ERR_W-1:0]  r_prev_err;
    logic signed [INT_W-1:0]  r_integral;
    logic signed [DERR_W-1:0] err_ext, mag;
    logic                     in_dz;
    logic signed [ACC_W-1:0]  acc, acc_lim;
    logic signed [INT_W-1:0]  n_integral;
    logic signed [ERR_W-1:0]  n_prev_err;
    logic signed [DERR_W-1:0] n_b_derr;

    logic signed [ERR_W-1:0]  r_b_err;
    logic signed [INT_W-1:0]  r_b_int;
    logic signed [DERR_W-1:0] r_b_derr;
    logic                     r_b_dz;

    always_comb begin
        err_ext = $signed({r_a_err[ERR_W-1], r_a_err});
        mag     = r_a_err[ERR_W-1] ? -err_ext : err_ext;
        in_dz   = !(mag > $signed({{(DERR_W-pidd_pkg::DZ_W){1'b0}}, r_dead_zone}));

        // Accumulate, then clamp symmetrically to the integral limit.
        acc_lim = $signed({{(ACC_W-pidd_pkg::ILIM_W){1'b0}}, r_int_limit});
        acc     = $signed({r_integral[INT_W-1], r_integral})
                + $signed({{(ACC_W-ERR_W){r_a_err[ERR_W-1]}}, r_a_err});
        if (acc > acc_lim) begin
            acc = acc_lim;
        end
        if (acc < -acc_lim) begin
            acc = -acc_lim;
        end

        n_b_derr = err_ext - $signed({r_prev_err[ERR_W-1], r_prev_err});

        if (in_dz) begin
            n_integral = '0;
            n_prev_err = '0;
        end else begin
            n_integral = acc[INT_W-1:0];
            n_prev_err = r_a_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_err <= '0;
            r_integral <= '0;
        end else if (adv_b && r_a_vld) begin
            r_prev_err <= n_prev_err;
            r_integral <= n_integral;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_b && r_a_vld) begin
            r_b_err  <= r_a_err;
            r_b_int  <= n_integral;
            r_b_derr <= n_b_derr;
            r_b_dz   <= in_dz;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: the three gain products. Dropping the low FRAC_BITS of an
    // exact product is the arithmetic right shift (round toward minus
    // infinity).
    // ------------------------------------------------------------------
    logic signed [P_W-1:0]  prod_p;
    logic signed [I_W-1:0]  prod_i;
    logic signed [D_W-1:0]  prod_d;
    logic signed [PS_W-1:0] r_c_p;
    logic signed [IS_W-1:0] r_c_i;
    logic signed [DS_W-1:0] r_c_d;
    logic                   r_c_dz;

    assign prod_p = P_W'(r_gain_p) * P_W'(r_b_err);
    assign prod_i = I_W'(r_gain_i) * I_W'(r_b_int);
    assign prod_d = D_W'(r_gain_d) * D_W'(r_b_derr);

    always_ff @(posedge i_clk) begin
        if (adv_c && r_b_vld) begin
            r_c_p  <= prod_p[P_W-1:FB];
            r_c_i  <= prod_i[I_W-1:FB];
            r_c_d  <= prod_d[D_W-1:FB];
            r_c_dz <= r_b_dz;
        end
    end

    // ------------------------------------------------------------------
    // Output stage: sum of the terms, symmetric output clamp, and zero
    // drive inside the deadband.
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] sum, out_lim;
    logic signed [15:0]      n_o_drive;
    logic signed [15:0]      r_o_drive;
    logic                    r_o_dz;

    always_comb begin
        out_lim = $signed({{(SUM_W-pidd_pkg::OLIM_W){1'b0}}, r_out_limit});
        sum = $signed({{(SUM_W-PS_W){r_c_p[PS_W-1]}}, r_c_p})
            + $signed({{(SUM_W-IS_W){r_c_i[IS_W-1]}}, r_c_i})
            + $signed({{(SUM_W-DS_W){r_c_d[DS_W-1]}}, r_c_d});
        if (sum > out_lim) begin
            sum = out_lim;
        end
        if (sum < -out_lim) begin
            sum = -out_lim;
        end
        n_o_drive = r_c_dz ? 16'sd0 : sum[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (adv_o && r_c_vld) begin
            r_o_drive <= n_o_drive;
            r_o_dz    <= r_c_dz;
        end
    end

    assign m_axis_tvalid   = r_o_vld;
    assign m_axis_tdata    = r_o_drive;
    assign m_axis_tuser[0] = r_o_dz;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A word inside the deadband always leaves with zero drive.
    a_dz_zero_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 16'd0)
        else $error("deadband result with nonzero drive");

    // Drive never leaves the configured output window.
    a_drive_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata) <= $signed({1'b0, r_out_limit}))
                       && ($signed(m_axis_tdata) >= -$signed({1'b0, r_out_limit})))
        else $error("drive outside output limit");

    // A deadband word clears the controller state as it passes stage B.
    a_dz_clears_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv_b && r_a_vld && in_dz |=> r_integral == '0 && r_prev_err == '0)
        else $error("deadband did not clear integral or previous error");

    // A result only appears when stage C held a word.
    a_out_from_c: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_c_vld))
        else $error("result word without a source");

endmodule : pid_controller_deadband_core

`default_nettype wire
